// ===== src/mfap_pkg.sv =====
// Package with payload types, codes and defaults for the max-flow block.
package mfap_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_ARCS     = 1024;
  localparam int DEF_CAP_WIDTH    = 16;

  localparam logic [31:0] FLOW_BOUND = 32'd1000000000;

  localparam logic       REQ_EDGE = 1'b0;
  localparam logic       REQ_RUN  = 1'b1;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_FLOW     = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  from_vertex;
    logic [5:0]  to_vertex;
    logic [15:0] edge_capacity;
  } mfap_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] max_flow;
  } mfap_rsp_t;

endpackage

// ===== src/max_flow_augmenting_path_core.sv =====
// Top level of the max-flow block: edge loading and the augmenting-path sequencer.
//
// This block loads a directed graph one edge per request transaction and, on a
// run request, computes the maximum flow from vertex 0 to vertex count minus one
// by repeated depth-first searches over the residual graph. Each accepted request
// yields exactly one response transaction. An edge load reads the vertex list
// head, then writes each of the two arcs in turn, then gives the response; a
// rejected edge goes straight to the response. A run takes a data-dependent
// time, set by the arcs examined, the backtracks and pushes of each search and
// the bottleneck and residual passes over each augmenting path, since the arc
// memories have a single read port. A final failed search ends the run. Flow
// accumulates over runs and saturates at 2^32 - 1. The vertex list heads and
// visited marks are flip-flop valid bits cleared by reset, so no clearing pass
// is needed. The block takes one request at a time, but a new request may be
// accepted while the previous response still waits.
module max_flow_augmenting_path_core
  import mfap_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_ARCS     = DEF_MAX_ARCS,
  parameter int CAP_WIDTH    = DEF_CAP_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  mfap_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output mfap_rsp_t rsp,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data
);

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AIW = $clog2(MAX_ARCS);
  localparam int AW  = $clog2(MAX_ARCS + 1);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = (CW > 7) ? CW : 7;
  localparam logic [AW-1:0] ARC_NULL = AW'(MAX_ARCS);

  typedef enum logic [4:0] {
    IDLE, E_RD, E_W0, E_W1,
    R_START, R_INIT, S_CHK, S_POP1, S_POP2, S_ARC, S_PUSH,
    B_RD, B_CAP, B_MIN, U_RD, U_CAP, U_FWD, U_REV, R_ADD, OUT
  } state_t;

  state_t state;

  logic [6:0]           vertex_count;
  logic [AW-1:0]        arc_count;
  logic [31:0]          flow_total;
  logic [31:0]          amount;
  logic [1:0]           res_status;
  logic [VW-1:0]        u_reg, v_reg;
  logic                 same_uv;
  logic [CAP_WIDTH-1:0] cap_reg;
  logic [AW-1:0]        top_arc;
  logic [AW-1:0]        arc_a;
  logic [VW:0]          depth;
  logic [VW-1:0]        idx;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] first_valid;
  logic                 first_valid_q;

  // Memory ports.
  logic                 first_we;
  logic [VW-1:0]        first_waddr, first_raddr;
  logic [AW-1:0]        first_wdata, first_rdata;
  logic                 link_we, cap_we;
  logic [AIW-1:0]       arc_waddr, arc_raddr;
  logic [VW-1:0]        head_wdata, head_rdata;
  logic [AW-1:0]        next_wdata, next_rdata;
  logic [CAP_WIDTH-1:0] cap_wdata, cap_rdata;
  logic                 stack_we;
  logic [VW-1:0]        stack_waddr, stack_raddr;
  logic [AW-1:0]        stack_wdata, stack_rdata;

  // Effective vertex count, clamped to the legal range, and the sink.
  logic [EW-1:0] eff_count;
  logic [VW-1:0] sink;
  logic [31:0]   cap_ext;
  logic          edge_bad;
  logic [AW-1:0] first_rd;
  logic          last_frame;
  logic [32:0]   flow_sum;

  always_comb begin
    if (vertex_count < 7'd2) begin
      eff_count = EW'(2);
    end else if (EW'(vertex_count) > EW'(MAX_VERTICES)) begin
      eff_count = EW'(MAX_VERTICES);
    end else begin
      eff_count = EW'(vertex_count);
    end
  end

  assign sink       = VW'(eff_count - EW'(1));
  assign cap_ext    = 32'(req.edge_capacity);
  assign edge_bad   = (EW'(req.from_vertex) >= eff_count) ||
                      (EW'(req.to_vertex) >= eff_count) ||
                      ((32'(arc_count) + 32'd2) > 32'(MAX_ARCS));
  // A vertex whose list was never written reads as an empty list.
  assign first_rd   = first_valid_q ? first_rdata : ARC_NULL;
  assign last_frame = ({1'b0, idx} == (depth - (VW+1)'(1)));
  assign flow_sum   = {1'b0, flow_total} + {1'b0, amount};
  assign req_ready  = (state == IDLE);

  // Memory address and write selection for each sequencer step.
  always_comb begin
    first_we    = 1'b0;
    first_waddr = u_reg;
    first_wdata = arc_count;
    first_raddr = u_reg;
    link_we     = 1'b0;
    cap_we      = 1'b0;
    arc_waddr   = arc_count[AIW-1:0];
    arc_raddr   = top_arc[AIW-1:0];
    head_wdata  = v_reg;
    next_wdata  = first_rd;
    cap_wdata   = cap_reg;
    stack_we    = 1'b0;
    stack_waddr = VW'(depth - (VW+1)'(1));
    stack_wdata = top_arc;
    stack_raddr = VW'(depth - (VW+1)'(2));
    case (state)
      E_W0: begin
        link_we     = 1'b1;
        cap_we      = 1'b1;
        next_wdata  = first_rd;
        first_we    = 1'b1;
        first_raddr = v_reg;
      end
      E_W1: begin
        link_we     = 1'b1;
        cap_we      = 1'b1;
        head_wdata  = u_reg;
        next_wdata  = same_uv ? arc_count : first_rd;
        cap_wdata   = '0;
        arc_waddr   = AIW'(arc_count + AW'(1));
        first_we    = 1'b1;
        first_waddr = v_reg;
        first_wdata = AW'(arc_count + AW'(1));
      end
      R_START: first_raddr = '0;
      S_POP1:  arc_raddr = stack_rdata[AIW-1:0];
      S_ARC: begin
        first_raddr = head_rdata;
        stack_we    = !visited[head_rdata] && (cap_rdata != '0) &&
                      ((head_rdata == sink) || (depth < (VW+1)'(MAX_VERTICES)));
      end
      B_RD, U_RD: stack_raddr = idx;
      B_CAP, U_CAP: arc_raddr = stack_rdata[AIW-1:0];
      U_FWD: begin
        cap_we    = 1'b1;
        arc_waddr = arc_a[AIW-1:0];
        cap_wdata = cap_rdata - amount[CAP_WIDTH-1:0];
        arc_raddr = {arc_a[AIW-1:1], ~arc_a[0]};
      end
      U_REV: begin
        cap_we    = 1'b1;
        arc_waddr = {arc_a[AIW-1:1], ~arc_a[0]};
        cap_wdata = cap_rdata + amount[CAP_WIDTH-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer: edge loading, search, bottleneck and residual update passes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      vertex_count <= 7'd64;
      arc_count    <= '0;
      flow_total   <= '0;
      first_valid  <= '0;
      visited      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      // In OUT the response register is reloaded instead of cleared.
      if (rsp_valid && rsp_ready && (state != OUT)) begin
        rsp_valid <= 1'b0;
      end
      first_valid_q <= first_valid[first_raddr];
      case (state)
        IDLE: begin
          if (req_valid) begin
            u_reg   <= VW'(req.from_vertex);
            v_reg   <= VW'(req.to_vertex);
            same_uv <= (req.from_vertex == req.to_vertex);
            cap_reg <= cap_ext[CAP_WIDTH-1:0];
            if (req.req_type == REQ_RUN) begin
              state <= R_START;
            end else if (edge_bad) begin
              res_status <= ST_REJECTED;
              state      <= OUT;
            end else begin
              state <= E_RD;
            end
          end
        end
        E_RD: state <= E_W0;
        E_W0: begin
          first_valid[u_reg] <= 1'b1;
          state              <= E_W1;
        end
        E_W1: begin
          first_valid[v_reg] <= 1'b1;
          arc_count          <= AW'(arc_count + AW'(2));
          res_status         <= ST_ADDED;
          state              <= OUT;
        end
        R_START: begin
          visited    <= MAX_VERTICES'(1);
          amount     <= FLOW_BOUND;
          state      <= R_INIT;
        end
        R_INIT: begin
          top_arc <= first_rd;
          depth   <= (VW+1)'(1);
          state   <= S_CHK;
        end
        S_CHK: begin
          if (top_arc == ARC_NULL) begin
            if (depth == (VW+1)'(1)) begin
              // No augmenting path is left: the run is finished.
              res_status <= ST_FLOW;
              state      <= OUT;
            end else begin
              state <= S_POP1;
            end
          end else begin
            state <= S_ARC;
          end
        end
        S_POP1: begin
          depth <= depth - (VW+1)'(1);
          state <= S_POP2;
        end
        S_POP2: begin
          top_arc <= next_rdata;
          state   <= S_CHK;
        end
        S_ARC: begin
          if (!visited[head_rdata] && (cap_rdata != '0) && (head_rdata == sink)) begin
            idx   <= '0;
            state <= B_RD;
          end else if (!visited[head_rdata] && (cap_rdata != '0) &&
                       (depth < (VW+1)'(MAX_VERTICES))) begin
            visited[head_rdata] <= 1'b1;
            state               <= S_PUSH;
          end else begin
            top_arc <= next_rdata;
            state   <= S_CHK;
          end
        end
        S_PUSH: begin
          top_arc <= first_rd;
          depth   <= depth + (VW+1)'(1);
          state   <= S_CHK;
        end
        B_RD:  state <= B_CAP;
        B_CAP: state <= B_MIN;
        B_MIN: begin
          if (32'(cap_rdata) < amount) begin
            amount <= 32'(cap_rdata);
          end
          if (last_frame) begin
            idx   <= '0;
            state <= U_RD;
          end else begin
            idx   <= idx + VW'(1);
            state <= B_RD;
          end
        end
        U_RD: state <= U_CAP;
        U_CAP: begin
          arc_a <= stack_rdata;
          state <= U_FWD;
        end
        U_FWD: state <= U_REV;
        U_REV: begin
          if (last_frame) begin
            state <= R_ADD;
          end else begin
            idx   <= idx + VW'(1);
            state <= U_RD;
          end
        end
        R_ADD: begin
          flow_total <= flow_sum[32] ? 32'hFFFF_FFFF : flow_sum[31:0];
          state      <= R_START;
        end
        OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.status     <= res_status;
            rsp.max_flow   <= (res_status == ST_FLOW) ? flow_total : '0;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  mfap_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_first (
    .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
    .raddr(first_raddr), .rdata(first_rdata)
  );

  mfap_ram #(.WIDTH(VW), .DEPTH(MAX_ARCS)) u_head (
    .clk(clk), .we(link_we), .waddr(arc_waddr), .wdata(head_wdata),
    .raddr(arc_raddr), .rdata(head_rdata)
  );

  mfap_ram #(.WIDTH(AW), .DEPTH(MAX_ARCS)) u_next (
    .clk(clk), .we(link_we), .waddr(arc_waddr), .wdata(next_wdata),
    .raddr(arc_raddr), .rdata(next_rdata)
  );

  mfap_ram #(.WIDTH(CAP_WIDTH), .DEPTH(MAX_ARCS)) u_cap (
    .clk(clk), .we(cap_we), .waddr(arc_waddr), .wdata(cap_wdata),
    .raddr(arc_raddr), .rdata(cap_rdata)
  );

  mfap_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
    .raddr(stack_raddr), .rdata(stack_rdata)
  );

endmodule

// ===== src/mfap_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module mfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mfap_checker.sv =====
// Port-level checker for the max-flow block, bound to the top level.
module mfap_checker
  import mfap_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input mfap_rsp_t rsp
);

  logic [31:0] last_flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_flow <= '0;
    end else if (rsp_valid && rsp_ready && rsp.status == ST_FLOW) begin
      last_flow <= rsp.max_flow;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("block ready again right after accepting a request");

  a_edge_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_ADDED || rsp.status == ST_REJECTED)
      |-> rsp.max_flow == '0)
    else $error("edge response carries a flow value");

  a_flow_grows: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FLOW |-> rsp.max_flow >= last_flow)
    else $error("accumulated flow decreased");

endmodule

bind max_flow_augmenting_path_core mfap_checker u_mfap_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
